FILE: hdl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types and constants for the CoDel drop decision block.
// ----------------------------------------------------------------------------
package cdd_pkg;

    // Time-base width default and fixed arithmetic widths
    localparam int TIME_BITS_DEF = 64;
    localparam int MUL_W         = 32;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int REENTRY_SHIFT = 4;

    // Reset values of registers and state, and arithmetic constants
    localparam logic [31:0] TARGET_RESET   = 32'd5000000;
    localparam logic [31:0] INTERVAL_RESET = 32'd100000000;
    localparam logic [15:0] LARGEST_RESET  = 16'd256;
    localparam logic [15:0] INV_ONE        = 16'hFFFF;
    localparam logic [31:0] NEWTON_THREE   = 32'd3;

    // Configuration register index (byte address / 4)
    typedef enum logic [0:0] {
        REG_TARGET   = 1'b0,
        REG_INTERVAL = 1'b1
    } t_reg_idx;

    // Result verdict
    typedef enum logic [1:0] {
        V_DELIVER = 2'd0,
        V_DROP    = 2'd1,
        V_EMPTY   = 2'd2
    } t_verdict;

    // Pending follow-up after a drop verdict
    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_ENTER = 2'd1,
        PH_DROP  = 2'd2
    } t_phase;

    // How the current request is judged
    typedef enum logic [1:0] {
        MODE_FRESH        = 2'd0,
        MODE_FOLLOW_ENTER = 2'd1,
        MODE_FOLLOW_DROP  = 2'd2
    } t_mode;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_SOJ,
        S_TGT,
        S_FA,
        S_DECIDE,
        S_CMP,
        S_RE1,
        S_RE2,
        S_N1,
        S_N2,
        S_N3,
        S_N4,
        S_N5,
        S_N6,
        S_L1,
        S_L2,
        S_OUT
    } t_state;

endpackage

FILE: hdl/cdd_mul.sv
// ----------------------------------------------------------------------------
// cdd_mul
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module cdd_mul (
    input  logic                           i_clk,
    input  logic [cdd_pkg::MUL_W-1:0]      i_a,
    input  logic [cdd_pkg::MUL_W-1:0]      i_b,
    output logic [2*cdd_pkg::MUL_W-1:0]    o_p
);

    logic [2*cdd_pkg::MUL_W-1:0] r_p;

    // product lands in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= (2*cdd_pkg::MUL_W)'(i_a) * (2*cdd_pkg::MUL_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: hdl/codel_drop_decision.sv
// ----------------------------------------------------------------------------
// codel_drop_decision
// CoDel dequeue drop decision: one verdict per head-of-line request.
// ----------------------------------------------------------------------------
// Each accepted request yields exactly one result. The block handles one
// request at a time: o_ready is high only while idle. An empty-queue request
// goes from S_START straight to S_OUT; a judged packet passes S_SOJ, S_TGT,
// S_FA and S_DECIDE. A follow-up that first advances the drop schedule, and a
// packet inside dropping mode, are then tested in S_CMP; a drop runs the Newton
// step. Entering dropping mode runs the re-entry test, the Newton step when
// the count resumes, and the control law. The long paths, the Newton step and
// the control law, run as products through one shared 32x32 multiplier. The
// next request is taken the cycle after the result is taken.
// Configuration writes are meant for idle periods only.
module codel_drop_decision #(
    parameter int TIME_BITS = cdd_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_kind,
    input  logic                         i_follows_drop,
    input  logic [63:0]                  i_now,
    input  logic [63:0]                  i_enqueue_stamp,
    input  logic [15:0]                  i_packet_length,
    input  logic [31:0]                  i_queue_bytes,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_verdict,
    output logic [63:0]                  o_sojourn_time,
    output logic                         o_in_drop_state,
    output logic [31:0]                  o_drop_count,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdd_pkg::ADDR_W-1:0]   paddr,
    input  logic [cdd_pkg::DATA_W-1:0]   pwdata,
    output logic [cdd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int MW = cdd_pkg::MUL_W;

    // configuration
    logic [31:0]            r_target;
    logic [31:0]            r_interval;

    // algorithm state
    cdd_pkg::t_state        r_state, n_state;
    logic                   r_dropping;
    cdd_pkg::t_phase        r_phase;
    logic [TIME_BITS-1:0]   r_fa;
    logic [TIME_BITS-1:0]   r_ndt;
    logic [31:0]            r_count;
    logic [31:0]            r_prev;
    logic [15:0]            r_inv;
    logic [15:0]            r_largest;
    logic [TIME_BITS-1:0]   r_time;

    // request and working registers
    cdd_pkg::t_mode         r_mode;
    logic                   r_empty;
    logic                   r_fd;
    cdd_pkg::t_phase        r_phase_in;
    logic [TIME_BITS-1:0]   r_stamp;
    logic [15:0]            r_len;
    logic [31:0]            r_qb;
    logic [TIME_BITS-1:0]   r_soj;
    logic                   r_below;
    logic                   r_d;
    logic [TIME_BITS-1:0]   r_acc;
    logic [61:0]            r_v;
    logic [63:0]            r_plo;
    logic                   r_law_ndt;
    logic                   r_law_after;
    cdd_pkg::t_verdict      r_verdict;

    // shared multiplier
    logic [MW-1:0]          mul_a, mul_b;
    logic [2*MW-1:0]        mul_p;

    // combinational datapath
    logic [31:0]            y;
    logic [TIME_BITS-1:0]   tgt_diff;
    logic                   fa_zero;
    logic [TIME_BITS-1:0]   fa_sum;
    logic [TIME_BITS-1:0]   ndt_diff;
    logic [TIME_BITS-1:0]   re_diff;
    logic [63:0]            v_full;
    logic [31:0]            inv_upper;
    logic [TIME_BITS-1:0]   law_base;
    logic [31:0]            re_count;
    logic                   req_acc;
    logic                   cfg_wr;

    cdd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign req_acc = i_valid && o_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // datapath arithmetic
    always_comb begin
        y         = {r_inv, 16'h0000};
        tgt_diff  = r_soj - TIME_BITS'(r_target);
        fa_zero   = (r_fa == '0);
        fa_sum    = fa_zero ? (r_time + TIME_BITS'(r_interval)) : (r_time - r_fa);
        ndt_diff  = r_time - r_ndt;
        re_diff   = r_acc - TIME_BITS'({r_interval, {cdd_pkg::REENTRY_SHIFT{1'b0}}});
        v_full    = {cdd_pkg::NEWTON_THREE, 32'h0} - mul_p;
        inv_upper = r_plo[63:32] + mul_p[31:0];
        law_base  = r_law_ndt ? r_ndt : r_time;
        re_count  = (r_count - r_prev) | 32'd1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdd_pkg::S_IDLE:   if (i_valid) n_state = cdd_pkg::S_START;
            cdd_pkg::S_START: begin
                if (r_empty) n_state = cdd_pkg::S_OUT;
                else         n_state = cdd_pkg::S_SOJ;
            end
            cdd_pkg::S_SOJ:    n_state = cdd_pkg::S_TGT;
            cdd_pkg::S_TGT:    n_state = cdd_pkg::S_FA;
            cdd_pkg::S_FA:     n_state = cdd_pkg::S_DECIDE;
            cdd_pkg::S_DECIDE: begin
                case (r_mode)
                    cdd_pkg::MODE_FOLLOW_DROP: begin
                        if (r_d) n_state = cdd_pkg::S_L1;
                        else     n_state = cdd_pkg::S_OUT;
                    end
                    cdd_pkg::MODE_FRESH: begin
                        if (r_dropping && r_d)  n_state = cdd_pkg::S_CMP;
                        else if (!r_dropping && r_d) n_state = cdd_pkg::S_RE1;
                        else                    n_state = cdd_pkg::S_OUT;
                    end
                    default:   n_state = cdd_pkg::S_OUT;
                endcase
            end
            cdd_pkg::S_CMP: begin
                if (!ndt_diff[TIME_BITS-1]) n_state = cdd_pkg::S_N1;
                else                        n_state = cdd_pkg::S_OUT;
            end
            cdd_pkg::S_RE1:    n_state = cdd_pkg::S_RE2;
            cdd_pkg::S_RE2: begin
                if (re_diff[TIME_BITS-1]) n_state = cdd_pkg::S_N1;
                else                      n_state = cdd_pkg::S_L1;
            end
            cdd_pkg::S_N1:     n_state = cdd_pkg::S_N2;
            cdd_pkg::S_N2:     n_state = cdd_pkg::S_N3;
            cdd_pkg::S_N3:     n_state = cdd_pkg::S_N4;
            cdd_pkg::S_N4:     n_state = cdd_pkg::S_N5;
            cdd_pkg::S_N5:     n_state = cdd_pkg::S_N6;
            cdd_pkg::S_N6: begin
                if (r_law_after) n_state = cdd_pkg::S_L1;
                else             n_state = cdd_pkg::S_OUT;
            end
            cdd_pkg::S_L1:     n_state = cdd_pkg::S_L2;
            cdd_pkg::S_L2: begin
                if (r_law_ndt) n_state = cdd_pkg::S_CMP;
                else           n_state = cdd_pkg::S_OUT;
            end
            cdd_pkg::S_OUT:    if (i_ready) n_state = cdd_pkg::S_IDLE;
            default:           n_state = cdd_pkg::S_IDLE;
        endcase
    end

    // state-driven outputs: handshakes and multiplier operands
    always_comb begin
        o_ready = (r_state == cdd_pkg::S_IDLE);
        o_valid = (r_state == cdd_pkg::S_OUT);
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            cdd_pkg::S_N1: begin
                mul_a = y;
                mul_b = y;
            end
            cdd_pkg::S_N2: begin
                mul_a = r_count;
                mul_b = mul_p[2*MW-1:MW];
            end
            cdd_pkg::S_N4: begin
                mul_a = r_v[MW-1:0];
                mul_b = y;
            end
            cdd_pkg::S_N5: begin
                mul_a = MW'(r_v[61:MW]);
                mul_b = y;
            end
            cdd_pkg::S_L1: begin
                mul_a = r_interval;
                mul_b = y;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cdd_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= cdd_pkg::TARGET_RESET;
            r_interval <= cdd_pkg::INTERVAL_RESET;
        end else if (cfg_wr) begin
            case (cdd_pkg::t_reg_idx'(paddr[cdd_pkg::ADDR_W-1]))
                cdd_pkg::REG_TARGET:   r_target   <= pwdata;
                cdd_pkg::REG_INTERVAL: r_interval <= pwdata;
                default:               r_target   <= r_target;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (cdd_pkg::t_reg_idx'(paddr[cdd_pkg::ADDR_W-1]))
            cdd_pkg::REG_TARGET:   prdata = r_target;
            cdd_pkg::REG_INTERVAL: prdata = r_interval;
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // algorithm state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dropping  <= 1'b0;
            r_phase     <= cdd_pkg::PH_NONE;
            r_fa        <= '0;
            r_ndt       <= '0;
            r_count     <= '0;
            r_prev      <= '0;
            r_inv       <= '0;
            r_largest   <= cdd_pkg::LARGEST_RESET;
            r_time      <= '0;
            r_law_ndt   <= 1'b0;
            r_law_after <= 1'b0;
            r_mode      <= cdd_pkg::MODE_FRESH;
        end else begin
            case (r_state)
                // take the request; a fresh one latches the time
                cdd_pkg::S_IDLE: begin
                    if (req_acc) begin
                        if (!i_follows_drop) r_time <= i_now[TIME_BITS-1:0];
                        r_phase_in <= r_phase;
                        r_phase    <= cdd_pkg::PH_NONE;
                    end
                end
                // classify; empty queue settles here
                cdd_pkg::S_START: begin
                    r_law_ndt   <= 1'b0;
                    r_law_after <= 1'b0;
                    if (r_fd && r_phase_in == cdd_pkg::PH_ENTER) begin
                        r_mode <= cdd_pkg::MODE_FOLLOW_ENTER;
                        if (r_empty) r_fa <= '0;
                    end else if (r_fd && r_phase_in == cdd_pkg::PH_DROP) begin
                        r_mode <= cdd_pkg::MODE_FOLLOW_DROP;
                        if (r_empty) begin
                            r_fa       <= '0;
                            r_dropping <= 1'b0;
                        end
                    end else begin
                        r_mode <= cdd_pkg::MODE_FRESH;
                        if (r_empty) r_dropping <= 1'b0;
                    end
                end
                // track largest packet
                cdd_pkg::S_SOJ: begin
                    if (r_len > r_largest) r_largest <= r_len;
                end
                // first-above tracking and sustained-above test
                cdd_pkg::S_FA: begin
                    if (r_below) begin
                        r_fa <= '0;
                        r_d  <= 1'b0;
                    end else if (fa_zero) begin
                        r_fa <= fa_sum;
                        r_d  <= 1'b0;
                    end else begin
                        r_d  <= (fa_sum != '0) && !fa_sum[TIME_BITS-1];
                    end
                end
                cdd_pkg::S_DECIDE: begin
                    case (r_mode)
                        cdd_pkg::MODE_FOLLOW_DROP: begin
                            if (!r_d) r_dropping <= 1'b0;
                            else      r_law_ndt  <= 1'b1;
                        end
                        cdd_pkg::MODE_FRESH: begin
                            if (r_dropping && !r_d) begin
                                r_dropping <= 1'b0;
                            end else if (!r_dropping && r_d) begin
                                r_dropping <= 1'b1;
                                r_phase    <= cdd_pkg::PH_ENTER;
                            end
                        end
                        default: r_dropping <= r_dropping;
                    endcase
                end
                // drop when the schedule is due
                cdd_pkg::S_CMP: begin
                    r_law_after <= 1'b0;
                    if (!ndt_diff[TIME_BITS-1]) begin
                        r_count <= r_count + 32'd1;
                        r_phase <= cdd_pkg::PH_DROP;
                    end
                end
                // re-entry: resume count if last schedule is recent
                cdd_pkg::S_RE2: begin
                    if (re_diff[TIME_BITS-1]) begin
                        r_count     <= re_count;
                        r_prev      <= re_count;
                        r_law_after <= 1'b1;
                    end else begin
                        r_count <= 32'd1;
                        r_prev  <= 32'd1;
                        r_inv   <= cdd_pkg::INV_ONE;
                    end
                end
                // Newton step result
                cdd_pkg::S_N6: r_inv <= inv_upper[30:15];
                // control law: next drop = base + interval * inv_root
                cdd_pkg::S_L2: r_ndt <= law_base + TIME_BITS'(mul_p[2*MW-1:MW]);
                default:       r_inv <= r_inv;
            endcase
        end
    end

    // request payload and scratch registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            cdd_pkg::S_IDLE: begin
                r_empty <= i_kind;
                r_fd    <= i_follows_drop;
                r_stamp <= i_enqueue_stamp[TIME_BITS-1:0];
                r_len   <= i_packet_length;
                r_qb    <= i_queue_bytes;
            end
            cdd_pkg::S_START: begin
                r_soj     <= '0;
                r_verdict <= r_empty ? cdd_pkg::V_EMPTY : cdd_pkg::V_DELIVER;
            end
            cdd_pkg::S_SOJ:  r_soj <= r_time - r_stamp;
            cdd_pkg::S_TGT:  r_below <= tgt_diff[TIME_BITS-1] || (r_qb <= 32'(r_largest));
            cdd_pkg::S_DECIDE: begin
                if (r_mode == cdd_pkg::MODE_FRESH && !r_dropping && r_d)
                    r_verdict <= cdd_pkg::V_DROP;
            end
            cdd_pkg::S_CMP: begin
                if (!ndt_diff[TIME_BITS-1]) r_verdict <= cdd_pkg::V_DROP;
            end
            cdd_pkg::S_RE1:  r_acc <= ndt_diff;
            cdd_pkg::S_N3:   r_v   <= v_full[63:2];
            cdd_pkg::S_N5:   r_plo <= mul_p;
            default:         r_acc <= r_acc;
        endcase
    end

    // result fields
    assign o_verdict       = r_verdict;
    assign o_sojourn_time  = 64'(r_soj);
    assign o_in_drop_state = r_dropping;
    assign o_drop_count    = r_count;

endmodule

FILE: tb/codel_drop_decision_tb.sv
// ----------------------------------------------------------------------------
// codel_drop_decision_tb
// Self-checking bench for the CoDel drop decision block. Directed requests
// from a short table cover the corner cases; random dequeue traffic follows
// under several register settings and idle/stall mixes. Each result is checked
// field by field against a row's fixed result or a cycle-free control-law model.
// ----------------------------------------------------------------------------
module codel_drop_decision_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYC   = 24;     // longest request path plus margin
    localparam int SETTLE_CYC  = 40;
    localparam int MAX_PRINTS  = 100;

    // One verdict as the block reports it
    typedef struct packed {
        cdd_pkg::t_verdict verdict;
        logic [63:0]       sojourn;
        logic              in_drop;
        logic [31:0]       count;
    } t_decision;

    localparam t_decision NO_WANT = '{cdd_pkg::V_DELIVER, 64'd0, 1'b0, 32'd0};

    // Directed request with an optional hand-written result
    typedef struct {
        logic        kind;
        logic        fd;
        logic [63:0] now;
        logic [63:0] stamp;
        logic [15:0] len;
        logic [31:0] qb;
        bit          fixed;
        t_decision   want;
    } t_dir_row;

    // DUT pins
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic                       i_kind = 1'b0;
    logic                       i_follows_drop = 1'b0;
    logic [63:0]                i_now = '0;
    logic [63:0]                i_enqueue_stamp = '0;
    logic [15:0]                i_packet_length = '0;
    logic [31:0]                i_queue_bytes = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_verdict;
    logic [63:0]                o_sojourn_time;
    logic                       o_in_drop_state;
    logic [31:0]                o_drop_count;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [cdd_pkg::ADDR_W-1:0] paddr = '0;
    logic [cdd_pkg::DATA_W-1:0] pwdata = '0;
    logic [cdd_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    codel_drop_decision dut (.*);

    always #5ns i_clk = ~i_clk;

    // Shadow registers and drop-law state
    logic [31:0]     cfg_target    = cdd_pkg::TARGET_RESET;
    logic [31:0]     cfg_interval  = cdd_pkg::INTERVAL_RESET;
    logic            m_dropping    = 1'b0;
    cdd_pkg::t_phase m_pend        = cdd_pkg::PH_NONE;
    logic [63:0]     m_first_above = '0;
    logic [63:0]     m_next_drop   = '0;
    logic [31:0]     m_drops       = '0;
    logic [31:0]     m_prev_cnt    = '0;
    logic [15:0]     m_inv_root    = '0;
    logic [15:0]     m_largest     = cdd_pkg::LARGEST_RESET;
    logic [63:0]     m_latched     = '0;

    t_decision   pending_decisions[$];
    t_dir_row    dir_rows[$];

    // Next request as built by the stimulus side
    logic        nx_kind, nx_fd;
    logic [63:0] nx_now, nx_stamp;
    logic [15:0] nx_len;
    logic [31:0] nx_qb;
    bit          nx_fixed;
    t_decision   nx_want;
    bit          fixed_on = 1'b0;
    t_decision   fixed_want = NO_WANT;

    // Traffic shaping
    int                int_idle_unused_guard = 0;
    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    int                rx_hold = 0;
    logic [63:0]       cursor_time = '0;
    bit                congested = 1'b1;
    cdd_pkg::t_verdict last_verdict = cdd_pkg::V_DELIVER;

    // Bookkeeping
    int          n_err = 0;
    int          n_req = 0;
    int          n_drop = 0;
    int          n_empty = 0;
    int          n_follow = 0;
    int          n_cycles = 0;
    logic [31:0] peak_count = '0;

    task automatic report_err(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        n_err++;
        if (n_err <= MAX_PRINTS)
            $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    // One Newton refinement of 1/sqrt(count), Q0.16
    function automatic void newton_step();
        logic [31:0] y, y2;
        logic [63:0] sq, v, pr;
        y  = {m_inv_root, 16'h0000};
        sq = 64'(y) * 64'(y);
        y2 = sq[63:32];
        v  = (64'(cdd_pkg::NEWTON_THREE) << 32) - 64'(m_drops) * 64'(y2);
        v  = v >> 2;
        pr = v * 64'(y);
        v  = pr >> 31;
        m_inv_root = v[31:16];
    endfunction

    // t + interval / sqrt(count)
    function automatic logic [63:0] control_law(input logic [63:0] t);
        logic [63:0] p;
        p = 64'(cfg_interval) * 64'({m_inv_root, 16'h0000});
        return t + 64'(p[63:32]);
    endfunction

    // Sojourn check; true once delay has stayed above target for an interval
    function automatic logic above_too_long(input logic [63:0] t, input logic [63:0] stamp,
                                            input logic [15:0] len, input logic [31:0] qb,
                                            output logic [63:0] soj);
        logic [63:0] d;
        logic [63:0] slack;
        soj = t - stamp;
        if (len > m_largest)
            m_largest = len;
        slack = soj - 64'(cfg_target);
        if (slack[63] || qb <= 32'(m_largest)) begin
            m_first_above = '0;
            return 1'b0;
        end
        if (m_first_above == '0) begin
            m_first_above = t + 64'(cfg_interval);
            return 1'b0;
        end
        d = t - m_first_above;
        return (d != '0) && !d[63];
    endfunction

    function automatic void count_drop();
        m_drops = m_drops + 32'd1;
        newton_step();
    endfunction

    // Verdict for one accepted request; advances the shadow state
    function automatic t_decision judge_request(input logic kind, input logic fd,
                                                input logic [63:0] now,
                                                input logic [63:0] stamp,
                                                input logic [15:0] len,
                                                input logic [31:0] qb);
        t_decision       r;
        cdd_pkg::t_phase ph;
        logic [63:0]     t, soj, late, reent;
        logic            hit;
        ph  = m_pend;
        m_pend = cdd_pkg::PH_NONE;
        soj = '0;
        r.verdict = cdd_pkg::V_DELIVER;
        if (!fd)
            m_latched = now;
        t = m_latched;

        if (fd && ph == cdd_pkg::PH_ENTER) begin
            if (kind) begin
                m_first_above = '0;
                r.verdict = cdd_pkg::V_EMPTY;
            end else begin
                hit = above_too_long(t, stamp, len, qb, soj);
            end
        end else if (fd && ph == cdd_pkg::PH_DROP) begin
            if (kind) begin
                m_first_above = '0;
                m_dropping = 1'b0;
                r.verdict = cdd_pkg::V_EMPTY;
            end else if (!above_too_long(t, stamp, len, qb, soj)) begin
                m_dropping = 1'b0;
            end else begin
                m_next_drop = control_law(m_next_drop);
                late = t - m_next_drop;
                if (!late[63]) begin
                    count_drop();
                    r.verdict = cdd_pkg::V_DROP;
                    m_pend = cdd_pkg::PH_DROP;
                end
            end
        end else if (kind) begin
            m_dropping = 1'b0;
            r.verdict = cdd_pkg::V_EMPTY;
        end else begin
            hit = above_too_long(t, stamp, len, qb, soj);
            if (m_dropping) begin
                late = t - m_next_drop;
                if (!hit) begin
                    m_dropping = 1'b0;
                end else if (!late[63]) begin
                    count_drop();
                    r.verdict = cdd_pkg::V_DROP;
                    m_pend = cdd_pkg::PH_DROP;
                end
            end else if (hit) begin
                r.verdict = cdd_pkg::V_DROP;
                m_pend = cdd_pkg::PH_ENTER;
                m_dropping = 1'b1;
                // resume the old count when re-entering within 16 intervals
                reent = t - m_next_drop - (64'(cfg_interval) << cdd_pkg::REENTRY_SHIFT);
                if (reent[63]) begin
                    m_drops = (m_drops - m_prev_cnt) | 32'd1;
                    newton_step();
                end else begin
                    m_drops = 32'd1;
                    m_inv_root = cdd_pkg::INV_ONE;
                end
                m_prev_cnt = m_drops;
                m_next_drop = control_law(t);
            end
        end

        r.sojourn = (r.verdict == cdd_pkg::V_EMPTY) ? 64'd0 : soj;
        r.in_drop = m_dropping;
        r.count   = m_drops;
        return r;
    endfunction

    // Request acceptance and result checking
    always @(posedge i_clk) begin
        t_decision w;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                w = judge_request(i_kind, i_follows_drop, i_now, i_enqueue_stamp,
                                  i_packet_length, i_queue_bytes);
                last_verdict = w.verdict;
                n_req++;
                if (w.verdict == cdd_pkg::V_DROP) n_drop++;
                if (w.verdict == cdd_pkg::V_EMPTY) n_empty++;
                if (i_follows_drop) n_follow++;
                if (w.count > peak_count) peak_count = w.count;
                pending_decisions.push_back(fixed_on ? fixed_want : w);
            end
            if (o_valid && i_ready) begin
                if (pending_decisions.size() == 0) begin
                    report_err("result with no request outstanding", 64'(o_verdict), '0);
                end else begin
                    w = pending_decisions.pop_front();
                    if (o_verdict !== w.verdict)
                        report_err("verdict", 64'(o_verdict), 64'(w.verdict));
                    if (o_sojourn_time !== w.sojourn)
                        report_err("sojourn_time", o_sojourn_time, w.sojourn);
                    if (o_in_drop_state !== w.in_drop)
                        report_err("in_drop_state", 64'(o_in_drop_state), 64'(w.in_drop));
                    if (o_drop_count !== w.count)
                        report_err("drop_count", 64'(o_drop_count), 64'(w.count));
                end
            end
        end
    end

    // Result side back-pressure; a hold-off request overrides the random stall
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("ERROR: run exceeded %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, pending_decisions.size());
            $display("codel_drop_decision: mismatch");
            $finish;
        end
    end

    // Offer the next request; returns at the falling edge after acceptance
    task automatic send_request();
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= nx_kind;
        i_follows_drop  <= nx_fd;
        i_now           <= nx_now;
        i_enqueue_stamp <= nx_stamp;
        i_packet_length <= nx_len;
        i_queue_bytes   <= nx_qb;
        fixed_on        <= nx_fixed;
        fixed_want      <= nx_want;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input cdd_pkg::t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cdd_pkg::ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            cdd_pkg::REG_TARGET:   cfg_target = val;
            cdd_pkg::REG_INTERVAL: cfg_interval = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_row(input logic kind, input logic fd, input logic [63:0] now,
                           input logic [63:0] stamp, input logic [15:0] len,
                           input logic [31:0] qb, input bit fixed, input t_decision want);
        t_dir_row r;
        r = '{kind, fd, now, stamp, len, qb, fixed, want};
        dir_rows.push_back(r);
    endtask

    // Dequeue traffic: mostly well-formed drop/follow-up chains, some noise
    task automatic make_random();
        int unsigned r;
        logic [63:0] base, soj;
        r = $urandom_range(0, 99);
        nx_fixed = 1'b0;
        nx_want  = NO_WANT;
        if (r < 7) begin
            nx_kind  = 1'($urandom);
            nx_fd    = 1'($urandom);
            nx_now   = {$urandom, $urandom};
            nx_stamp = {$urandom, $urandom};
            nx_len   = 16'($urandom);
            nx_qb    = $urandom;
            return;
        end
        if (last_verdict == cdd_pkg::V_DROP && r < 92) begin
            // next packet of the same dequeue; now is ignored
            nx_fd   = 1'b1;
            nx_now  = {$urandom, $urandom};
            base    = m_latched;
            nx_kind = ($urandom_range(0, 9) == 0);
        end else begin
            nx_fd       = (r < 10);
            cursor_time = cursor_time + 64'($urandom_range(0, (cfg_interval >> 2) + 1));
            nx_now      = cursor_time;
            base        = nx_fd ? m_latched : cursor_time;
            nx_kind     = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, congested ? 59 : 29) == 0)
                congested = !congested;
        end
        if (congested && $urandom_range(0, 9) != 0)
            soj = 64'(cfg_target) + 64'd1 + 64'($urandom_range(0, cfg_target >> 1));
        else
            soj = 64'($urandom_range(0, cfg_target));
        nx_stamp = base - soj;
        nx_len   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
        nx_qb    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2000)
                                               : $urandom_range(70000, 3000000);
    endtask

    task automatic run_phase(input logic [31:0] tgt, input logic [31:0] ivl,
                             input int tx_pct, input int rx_pct, input int n_items,
                             input logic [63:0] start_at, input bit pressure);
        drain();
        write_reg(cdd_pkg::REG_TARGET, tgt);
        write_reg(cdd_pkg::REG_INTERVAL, ivl);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        cursor_time  = start_at;
        for (int k = 0; k < n_items; k++) begin
            if (pressure && k == n_items / 3)
                rx_hold = 400;          // the result is held back, input must stall
            if (pressure && k == 2 * n_items / 3)
                drain();
            make_random();
            send_request();
        end
    endtask

    initial begin
        logic [63:0] a0, iv, tg;
        a0 = 64'd10_000_000_000;
        iv = 64'(cdd_pkg::INTERVAL_RESET);
        tg = 64'(cdd_pkg::TARGET_RESET);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults for target and interval
        // empty queue straight after reset
        add_row(1, 0, 0, 0, 0, 0, 1, '{cdd_pkg::V_EMPTY, 64'd0, 1'b0, 32'd0});
        // zero sojourn, zero length and backlog
        add_row(0, 0, 1000, 1000, 0, 0, 1, '{cdd_pkg::V_DELIVER, 64'd0, 1'b0, 32'd0});
        // follow-up with nothing pending: judged on the latched time, now ignored
        add_row(0, 1, '1, 0, 1, '1, 1, '{cdd_pkg::V_DELIVER, 64'd1000, 1'b0, 32'd0});
        // above target: arm first_above, then enter dropping one interval later
        add_row(0, 0, a0, a0 - 2 * tg, 1500, 100000, 0, NO_WANT);
        add_row(0, 0, a0 + iv + 1, a0 + iv + 1 - 2 * tg, 1500, 100000, 0, NO_WANT);
        // next packet after entering
        add_row(0, 1, 64'h0123_4567_89AB_CDEF, a0 + iv + 1 - 4 * tg, 64, 100000, 0, NO_WANT);
        // in dropping mode, before the next scheduled drop
        add_row(0, 0, a0 + iv + 20000000, a0 + iv + 20000000 - 2 * tg, 1500, 100000, 0,
                NO_WANT);
        // scheduled drop inside dropping mode, then its follow-ups
        add_row(0, 0, a0 + 3 * iv, a0 + 3 * iv - 2 * tg, 1500, 100000, 0, NO_WANT);
        add_row(0, 1, 0, a0 + 3 * iv - 3 * tg, 1500, 100000, 0, NO_WANT);
        add_row(1, 1, 0, 0, 0, 0, 0, NO_WANT);
        // re-entry within 16 intervals resumes from the previous count
        add_row(0, 0, a0 + 5 * iv, a0 + 5 * iv - 2 * tg, 1500, 100000, 0, NO_WANT);
        add_row(0, 0, a0 + 6 * iv + 1, a0 + 6 * iv + 1 - 2 * tg, 1500, 100000, 0, NO_WANT);
        // fresh request abandons the pending follow-up
        add_row(0, 0, a0 + 6 * iv + 10, a0 + 6 * iv + 10 - 2 * tg, 1500, 100000, 0, NO_WANT);
        // empty while dropping
        add_row(1, 0, a0 + 6 * iv + 20, 0, 0, 0, 0, NO_WANT);
        // enter again, then the queue runs empty on the follow-up
        add_row(0, 0, a0 + 6 * iv + 30, a0 + 6 * iv + 30 - 2 * tg, 1500, 100000, 0, NO_WANT);
        add_row(1, 1, '1, 0, 0, 0, 0, NO_WANT);
        add_row(0, 0, a0 + 6 * iv + 40, a0 + 6 * iv + 40 - 2 * tg, 1500, 100000, 0, NO_WANT);
        // backlog no larger than the largest packet
        add_row(0, 0, a0 + 7 * iv, a0 + 7 * iv - 2 * tg, 1500, 256, 0, NO_WANT);
        add_row(0, 0, a0 + 7 * iv + 5, 0, 16'hFFFF, 32'd65535, 0, NO_WANT);
        // extreme stamps: maximal and negative sojourn
        add_row(0, 0, '1, 0, 16'hFFFF, '1, 0, NO_WANT);
        add_row(0, 0, 100, 200, 0, '1, 0, NO_WANT);
        // long delay far past the re-entry window
        add_row(0, 0, 64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FF00_0000, 100, '1, 0, NO_WANT);
        add_row(0, 0, 64'h4000_0000_0800_0000, 64'h3FFF_FFFF_FF00_0000, 100, '1, 0, NO_WANT);

        foreach (dir_rows[k]) begin
            nx_kind  = dir_rows[k].kind;
            nx_fd    = dir_rows[k].fd;
            nx_now   = dir_rows[k].now;
            nx_stamp = dir_rows[k].stamp;
            nx_len   = dir_rows[k].len;
            nx_qb    = dir_rows[k].qb;
            nx_fixed = dir_rows[k].fixed;
            nx_want  = dir_rows[k].want;
            send_request();
        end

        // Random traffic under several register settings and idle mixes
        run_phase(cdd_pkg::TARGET_RESET, cdd_pkg::INTERVAL_RESET, 0, 0, 300,
                  64'd50_000_000_000, 0);
        run_phase(32'd100, 32'd1000, 84, 0, 300, 64'd1_000_000, 0);
        run_phase(32'd0, 32'd0, 0, 84, 150, 64'd5, 0);
        run_phase('1, '1, 15, 15, 200, 64'h0000_1000_0000_0000, 0);
        run_phase(32'd250, 32'd4000, 15, 15, 300, 64'hFFFF_FFFF_FFFF_8000, 1);
        run_phase(32'd4000, 32'd65535, 0, 0, 300, 64'h7FFF_FFFF_FFF0_0000, 0);

        drain();
        repeat (SETTLE_CYC) @(negedge i_clk);

        $display("Run covered %0d requests: %0d drops, %0d empty, %0d follow-ups, peak count %0d",
                 n_req, n_drop, n_empty, n_follow, peak_count);
        $display("Settings from zero to all-ones, idle/stall mixes, long result hold-off");
        if (n_err == 0) begin
            $display("codel_drop_decision: match");
        end else begin
            $display("codel_drop_decision: mismatch");
        end
        $finish;
    end

endmodule
